@@ rtl/core/bpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types and constants for the battery power state controller: power
// states, request codes, charge status codes, register map and the charge
// estimate constants.
// ----------------------------------------------------------------------------
package bpsc_pkg;

  // Power state machine
  typedef enum logic [1:0] {
    PS_STANDBY  = 2'd0,
    PS_POWERED  = 2'd1,
    PS_EXT_DOWN = 2'd2
  } pwr_mode_e;

  // User request codes
  typedef enum logic [1:0] {
    REQ_NONE        = 2'd0,
    REQ_UP          = 2'd1,
    REQ_UP_EXT_DOWN = 2'd2,
    REQ_DOWN        = 2'd3
  } request_e;

  // Charger status codes
  typedef enum logic [1:0] {
    CS_NOT_CHARGING = 2'd0,
    CS_FAST         = 2'd1,
    CS_COMPLETE     = 2'd2
  } charge_status_e;

  // Register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_AUTO_RECOVER = 2'd0,
    REG_EXT_DOWN_THR = 2'd1,
    REG_CRIT_THR     = 2'd2,
    REG_RECOVER_HYST = 2'd3
  } cfg_idx_e;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam int unsigned MvW     = 13;
  localparam int unsigned ChargeW = 10;
  localparam int unsigned ThrW    = 10;

  // Samples at or below this are treated as invalid
  localparam logic [MvW-1:0] MvValidMin = 13'd100;
  localparam logic [MvW-1:0] VsysLowMv  = 13'd3000;

  // Charge estimate: (14292*mV - 45293000) / 10000 between the clamp points
  localparam logic [MvW-1:0]     ChgMvLo    = 13'd3170;
  localparam logic [MvW-1:0]     ChgMvHi    = 13'd3868;
  localparam logic [13:0]        ChgSlope   = 14'd14292;
  localparam int unsigned        ChgOffset  = 45293000;
  // Numerator at the lower clamp point, so the span only needs mV - 3170
  localparam int unsigned        ChgBase    = 14292 * 3170 - ChgOffset;
  localparam int unsigned        ChgSpanW   = 10;
  localparam int unsigned        ChgNumW    = 24;
  // Reciprocal of 10000 scaled by 2^38, rounded up; exact for numerators < 2^24
  localparam logic [24:0]        ChgRecip   = 25'd27487791;
  localparam int unsigned        ChgShift   = 38;
  localparam int unsigned        ChgProdW   = ChgNumW + 25;
  localparam logic [ChargeW-1:0] ChgFull    = 10'd1000;
  localparam logic [ChargeW-1:0] ChgDoneMin = 10'd950;

  // Reset values of the configuration registers
  localparam logic            AutoRecoverRst = 1'b1;
  localparam logic [ThrW-1:0] ExtDownThrRst  = 10'd150;
  localparam logic [ThrW-1:0] CritThrRst     = 10'd50;
  localparam logic [ThrW-1:0] RecoverHystRst = 10'd100;

  // One result item
  typedef struct packed {
    pwr_mode_e            pwr_mode;
    logic                 rail_3v3_on;
    logic                 rail_5v_10v_on;
    logic                 rail_12v_off;
    logic                 vref_on;
    logic [ChargeW-1:0]   charge_tenths;
    charge_status_e       charge_status;
    logic                 ext_source;
    logic                 vsys_low;
  } result_t;

endpackage

@@ rtl/core/bpsc_charge_est.sv @@
// ----------------------------------------------------------------------------
// bpsc_charge_est
// Two-stage charge estimate from the stored battery voltage: a slope multiply
// then a reciprocal multiply for the divide by 10000, with clamping.
// ----------------------------------------------------------------------------
module bpsc_charge_est (
  input  logic                          clk_i,
  input  logic [bpsc_pkg::MvW-1:0]      mv_i,
  output logic [bpsc_pkg::ChargeW-1:0]  charge_o,
  output logic                          vsys_low_o
);

  logic [bpsc_pkg::ChgSpanW-1:0] span;
  logic [bpsc_pkg::ChgNumW-1:0]  num_d, num_q;
  logic                          lo_d, lo_q;
  logic                          hi_d, hi_q;
  logic                          vlow_d, vlow_q;
  logic [bpsc_pkg::ChgProdW-1:0] prod;
  logic [bpsc_pkg::ChargeW-1:0]  charge_d, charge_q;
  logic                          vlow2_q;

  // Stage A: numerator relative to the lower clamp point, plus range flags
  assign span   = bpsc_pkg::ChgSpanW'(mv_i - bpsc_pkg::ChgMvLo);
  assign num_d  = bpsc_pkg::ChgNumW'(bpsc_pkg::ChgSlope * span)
                + bpsc_pkg::ChgNumW'(bpsc_pkg::ChgBase);
  assign lo_d   = mv_i < bpsc_pkg::ChgMvLo;
  assign hi_d   = mv_i > bpsc_pkg::ChgMvHi;
  assign vlow_d = mv_i < bpsc_pkg::VsysLowMv;

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    vlow_q <= vlow_d;
  end

  // Stage B: divide by 10000 as multiply by scaled reciprocal, then clamp
  assign prod = bpsc_pkg::ChgProdW'(num_q) * bpsc_pkg::ChgProdW'(bpsc_pkg::ChgRecip);

  always_comb begin
    if (lo_q) begin
      charge_d = '0;
    end else if (hi_q) begin
      charge_d = bpsc_pkg::ChgFull;
    end else begin
      charge_d = prod[bpsc_pkg::ChgShift +: bpsc_pkg::ChargeW];
    end
  end

  always_ff @(posedge clk_i) begin
    charge_q <= charge_d;
    vlow2_q  <= vlow_q;
  end

  assign charge_o   = charge_q;
  assign vsys_low_o = vlow2_q;

endmodule

@@ rtl/core/bpsc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// bpsc_out_fifo
// Small result buffer between the state update and the output channel.
// Writer guarantees room; reads are the output channel transfers.
// ----------------------------------------------------------------------------
module bpsc_out_fifo #(
  parameter int unsigned Depth = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  bpsc_pkg::result_t   wr_data_i,
  input  logic                rd_i,
  output logic                valid_o,
  output bpsc_pkg::result_t   rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bpsc_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // Storage write
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign valid_o   = cnt_q != '0;
  assign rd_data_o = mem_q[rd_ptr_q];

endmodule

@@ rtl/core/battery_power_state_controller_unit.sv @@
// ----------------------------------------------------------------------------
// battery_power_state_controller_unit
// Per-tick battery charge estimate and three-state power rail controller
// with an APB-style register port.
// ----------------------------------------------------------------------------
// Takes one update tick per cycle while input ready is high. A tick's result
// becomes ready to transfer after one input register, the two multiply
// stages of the charge estimate, then the power state update that writes the
// result buffer. The result buffer holds OutDepth entries and input ready
// drops once OutDepth ticks are outstanding, so OutDepth must be at least 5
// to sustain one tick per cycle with the output always ready. Registers:
// 0x0 auto recover enable, 0x4 external rail drop threshold, 0x8 critical
// threshold, 0xC recovery hysteresis (charge values in tenths of a percent).
// Write registers only while no ticks are outstanding.
// ----------------------------------------------------------------------------
module battery_power_state_controller_unit #(
  parameter int unsigned OutDepth = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpsc_pkg::ApbAddrW-1:0]       paddr,
  input  logic [bpsc_pkg::ApbDataW-1:0]       pwdata,
  output logic [bpsc_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready,
  // Tick input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          request_i,
  input  logic [bpsc_pkg::MvW-1:0]            battery_mv_i,
  input  logic                                vbus_present_i,
  input  logic                                charging_i,
  input  logic                                shutdown_notified_i,
  // Result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          pwr_mode_o,
  output logic                                rail_3v3_on_o,
  output logic                                rail_5v_10v_on_o,
  output logic                                rail_12v_off_o,
  output logic                                vref_on_o,
  output logic [bpsc_pkg::ChargeW-1:0]        charge_tenths_o,
  output logic [1:0]                          charge_status_o,
  output logic                                ext_source_o,
  output logic                                vsys_low_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  typedef struct packed {
    bpsc_pkg::request_e req;
    logic               vbus;
    logic               chg_pin;
    logic               shut;
  } tick_t;

  // Configuration registers
  logic                        auto_rec_q;
  logic [bpsc_pkg::ThrW-1:0]   ext_thr_q;
  logic [bpsc_pkg::ThrW-1:0]   crit_thr_q;
  logic [bpsc_pkg::ThrW-1:0]   hyst_q;
  bpsc_pkg::cfg_idx_e          cfg_idx;
  logic                        cfg_wr;

  // Pipeline
  logic                        in_xfer, out_xfer;
  logic [CntW-1:0]             out_cnt_q, out_cnt_d;
  logic [bpsc_pkg::MvW-1:0]    last_mv_q;
  tick_t                       s1_q, s2_q, s3_q;
  logic                        v1_q, v2_q, v3_q;
  logic [bpsc_pkg::ChargeW-1:0] charge;
  logic                        vlow;

  // Power state machine
  bpsc_pkg::pwr_mode_e         state_q, state_d, st_eff;
  bpsc_pkg::request_e          req_eff;
  logic                        en3_q, en3_d;
  logic                        en5_q, en5_d;
  logic                        off12_q, off12_d;
  logic                        vref_q, vref_d;
  logic                        up_req, up_ok, up_en5, rec_ok, drop_ext, crit;
  logic [bpsc_pkg::ThrW:0]     rec_level;
  bpsc_pkg::charge_status_e    cstat;
  bpsc_pkg::result_t           res, out_res;

  // --------------------------------------------------------------------------
  // Register port
  assign pready  = 1'b1;
  assign cfg_idx = bpsc_pkg::cfg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_rec_q <= bpsc_pkg::AutoRecoverRst;
      ext_thr_q  <= bpsc_pkg::ExtDownThrRst;
      crit_thr_q <= bpsc_pkg::CritThrRst;
      hyst_q     <= bpsc_pkg::RecoverHystRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bpsc_pkg::REG_AUTO_RECOVER: auto_rec_q <= pwdata[0];
        bpsc_pkg::REG_EXT_DOWN_THR: ext_thr_q  <= pwdata[bpsc_pkg::ThrW-1:0];
        bpsc_pkg::REG_CRIT_THR:     crit_thr_q <= pwdata[bpsc_pkg::ThrW-1:0];
        bpsc_pkg::REG_RECOVER_HYST: hyst_q     <= pwdata[bpsc_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (cfg_idx)
      bpsc_pkg::REG_AUTO_RECOVER: prdata = bpsc_pkg::ApbDataW'(auto_rec_q);
      bpsc_pkg::REG_EXT_DOWN_THR: prdata = bpsc_pkg::ApbDataW'(ext_thr_q);
      bpsc_pkg::REG_CRIT_THR:     prdata = bpsc_pkg::ApbDataW'(crit_thr_q);
      bpsc_pkg::REG_RECOVER_HYST: prdata = bpsc_pkg::ApbDataW'(hyst_q);
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: count ticks taken but not yet transferred out
  assign in_ready_o = out_cnt_q < CntW'(OutDepth);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_o && out_ready_i;

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (in_xfer && !out_xfer) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (!in_xfer && out_xfer) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  // Valid chain and stored battery voltage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      last_mv_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      v1_q      <= in_xfer;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      if (in_xfer && (battery_mv_i > bpsc_pkg::MvValidMin)) begin
        last_mv_q <= battery_mv_i;
      end
    end
  end

  // Tick fields travel alongside the charge estimate
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.req     <= bpsc_pkg::request_e'(request_i);
      s1_q.vbus    <= vbus_present_i;
      s1_q.chg_pin <= charging_i;
      s1_q.shut    <= shutdown_notified_i;
    end
    s2_q <= s1_q;
    s3_q <= s2_q;
  end

  // last_mv_q holds the stored voltage of the tick in stage 1
  bpsc_charge_est u_charge (
    .clk_i      (clk_i),
    .mv_i       (last_mv_q),
    .charge_o   (charge),
    .vsys_low_o (vlow)
  );

  // --------------------------------------------------------------------------
  // State update conditions (stage 3)
  assign st_eff    = (s3_q.req == bpsc_pkg::REQ_DOWN) ? bpsc_pkg::PS_STANDBY : state_q;
  assign req_eff   = (s3_q.req == bpsc_pkg::REQ_DOWN) ? bpsc_pkg::REQ_NONE : s3_q.req;
  assign up_req    = (req_eff == bpsc_pkg::REQ_UP) || (req_eff == bpsc_pkg::REQ_UP_EXT_DOWN);
  assign up_ok     = !vlow || s3_q.vbus;
  assign up_en5    = (req_eff == bpsc_pkg::REQ_UP) && (s3_q.vbus || (charge >= ext_thr_q));
  assign rec_level = {1'b0, ext_thr_q} + {1'b0, hyst_q};
  assign rec_ok    = s3_q.vbus || ({1'b0, charge} >= rec_level);
  assign drop_ext  = (req_eff == bpsc_pkg::REQ_UP_EXT_DOWN)
                  || (!s3_q.vbus && (charge < ext_thr_q));
  assign crit      = !s3_q.vbus && (charge < crit_thr_q);

  // Next state
  always_comb begin
    state_d = state_q;
    if (v3_q) begin
      state_d = st_eff;
      unique case (st_eff)
        bpsc_pkg::PS_STANDBY: begin
          if (up_req && up_ok) begin
            state_d = up_en5 ? bpsc_pkg::PS_POWERED : bpsc_pkg::PS_EXT_DOWN;
          end
        end
        bpsc_pkg::PS_POWERED: begin
          if (drop_ext) begin
            state_d = bpsc_pkg::PS_EXT_DOWN;
          end
        end
        bpsc_pkg::PS_EXT_DOWN: begin
          if (rec_ok && (auto_rec_q || (req_eff == bpsc_pkg::REQ_UP))) begin
            state_d = bpsc_pkg::PS_POWERED;
          end else if ((req_eff != bpsc_pkg::REQ_UP) && crit) begin
            state_d = bpsc_pkg::PS_STANDBY;
          end
        end
        default: state_d = state_q;
      endcase
    end
  end

  // Rail enables
  always_comb begin
    en3_d   = en3_q;
    en5_d   = en5_q;
    off12_d = off12_q;
    vref_d  = vref_q;
    if (v3_q) begin
      unique case (st_eff)
        bpsc_pkg::PS_STANDBY: begin
          if (up_req && up_ok) begin
            en3_d   = 1'b1;
            en5_d   = up_en5;
            off12_d = 1'b0;
            vref_d  = 1'b1;
          end else if (!up_req && s3_q.shut) begin
            // shutdown pulse: everything off, 3V3 included
            en3_d   = 1'b0;
            en5_d   = 1'b0;
            off12_d = 1'b1;
            vref_d  = 1'b0;
          end
        end
        bpsc_pkg::PS_POWERED: begin
          if (drop_ext) begin
            en5_d = 1'b0;
          end
        end
        bpsc_pkg::PS_EXT_DOWN: begin
          if (rec_ok && (auto_rec_q || (req_eff == bpsc_pkg::REQ_UP))) begin
            en5_d = 1'b1;
          end else if ((req_eff != bpsc_pkg::REQ_UP) && crit) begin
            en5_d   = 1'b0;
            off12_d = 1'b1;
            vref_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpsc_pkg::PS_STANDBY;
      en3_q   <= 1'b1;
      en5_q   <= 1'b0;
      off12_q <= 1'b1;
      vref_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      en3_q   <= en3_d;
      en5_q   <= en5_d;
      off12_q <= off12_d;
      vref_q  <= vref_d;
    end
  end

  // Charger status
  always_comb begin
    if (s3_q.chg_pin) begin
      cstat = bpsc_pkg::CS_FAST;
    end else if (s3_q.vbus && (charge >= bpsc_pkg::ChgDoneMin)) begin
      cstat = bpsc_pkg::CS_COMPLETE;
    end else begin
      cstat = bpsc_pkg::CS_NOT_CHARGING;
    end
  end

  // Result item, values after the tick
  always_comb begin
    res.pwr_mode       = state_d;
    res.rail_3v3_on    = en3_d;
    res.rail_5v_10v_on = en5_d;
    res.rail_12v_off   = off12_d;
    res.vref_on        = vref_d;
    res.charge_tenths  = charge;
    res.charge_status  = cstat;
    res.ext_source     = s3_q.vbus;
    res.vsys_low       = vlow;
  end

  // --------------------------------------------------------------------------
  // Result buffer and output ports
  bpsc_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (v3_q),
    .wr_data_i (res),
    .rd_i      (out_xfer),
    .valid_o   (out_valid_o),
    .rd_data_o (out_res)
  );

  assign pwr_mode_o       = out_res.pwr_mode;
  assign rail_3v3_on_o    = out_res.rail_3v3_on;
  assign rail_5v_10v_on_o = out_res.rail_5v_10v_on;
  assign rail_12v_off_o   = out_res.rail_12v_off;
  assign vref_on_o        = out_res.vref_on;
  assign charge_tenths_o  = out_res.charge_tenths;
  assign charge_status_o  = out_res.charge_status;
  assign ext_source_o     = out_res.ext_source;
  assign vsys_low_o       = out_res.vsys_low;

  // --------------------------------------------------------------------------
  // Assertions

  // outstanding ticks never exceed the buffer
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= CntW'(OutDepth))
    else $error("outstanding tick count exceeds result buffer depth");

  // a buffered result always has a tick accounted for it
  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_cnt_q != '0))
    else $error("result valid with no outstanding tick");

  // powered up: every rail on
  a_powered_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpsc_pkg::PS_POWERED) |-> (en3_q && en5_q && !off12_q && vref_q))
    else $error("rail enables inconsistent with powered state");

  // external rails down: only the external rails off
  a_extdown_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpsc_pkg::PS_EXT_DOWN) |-> (en3_q && !en5_q && !off12_q && vref_q))
    else $error("rail enables inconsistent with external rails down state");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the battery power state controller. A directed
// table covers reset values, the sample and charge extremes and the
// power-machine corner cases. Random phases follow, each opening with
// register writes. Every result transfer is checked field by field against
// the table's value or an in-bench predictor of the rail controller.
// ----------------------------------------------------------------------------
module testbench;
  import bpsc_pkg::*;

  localparam int unsigned Limit      = 100000; // far above the slowest correct run
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PerPhase   = 157;
  localparam int unsigned TailCycles = 20;

  // One update tick as offered to the block
  typedef struct {
    request_e     req;
    logic [MvW-1:0] mv;
    logic         vbus;
    logic         charging;
    logic         shut;
  } tick_t;

  // Row of the directed table; want is only used when typed is set
  typedef struct {
    tick_t   t;
    bit      typed;
    result_t want;
  } row_t;

  localparam result_t Untyped = '0;
  localparam result_t IdleFlat = '{PS_STANDBY, 1'b1, 1'b0, 1'b1, 1'b0, 10'd0,
                                   CS_NOT_CHARGING, 1'b0, 1'b1};
  localparam result_t IdleFull = '{PS_STANDBY, 1'b1, 1'b0, 1'b1, 1'b0, 10'd1000,
                                   CS_FAST, 1'b0, 1'b0};

  logic clk;
  logic rst_n = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [1:0]     request = REQ_NONE;
  logic [MvW-1:0] battery_mv = '0;
  logic           vbus_present = 1'b0;
  logic           charging = 1'b0;
  logic           shutdown_notified = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         pwr_mode;
  logic               rail_3v3_on;
  logic               rail_5v_10v_on;
  logic               rail_12v_off;
  logic               vref_on;
  logic [ChargeW-1:0] charge_tenths;
  logic [1:0]         charge_status;
  logic               ext_source;
  logic               vsys_low;

  // Predictor copy of the registers and the controller state
  logic            cfg_auto = AutoRecoverRst;
  logic [ThrW-1:0] cfg_ext_thr = ExtDownThrRst;
  logic [ThrW-1:0] cfg_crit_thr = CritThrRst;
  logic [ThrW-1:0] cfg_hyst = RecoverHystRst;

  pwr_mode_e      pm_state = PS_STANDBY;
  logic           pm_en3v3 = 1'b1;
  logic           pm_en5v = 1'b0;
  logic           pm_off12 = 1'b1;
  logic           pm_vref = 1'b0;
  logic [MvW-1:0] pm_last_mv = '0;

  result_t pending_status_q[$];
  row_t    dir_rows [22];

  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;
  int unsigned state_hits [3] = '{0, 0, 0};
  bit          hold_req = 1'b0;

  // Random walk of the battery sample and sticky VBUS level
  int walk_mv = 3500;
  bit vbus_level = 1'b0;

  battery_power_state_controller_unit dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .request_i           (request),
    .battery_mv_i        (battery_mv),
    .vbus_present_i      (vbus_present),
    .charging_i          (charging),
    .shutdown_notified_i (shutdown_notified),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .pwr_mode_o          (pwr_mode),
    .rail_3v3_on_o       (rail_3v3_on),
    .rail_5v_10v_on_o    (rail_5v_10v_on),
    .rail_12v_off_o      (rail_12v_off),
    .vref_on_o           (vref_on),
    .charge_tenths_o     (charge_tenths),
    .charge_status_o     (charge_status),
    .ext_source_o        (ext_source),
    .vsys_low_o          (vsys_low)
  );

  // Clock, period 10
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Advance the predicted controller by one tick and return its status
  function automatic result_t rail_controller_step(input tick_t t);
    result_t     r;
    int unsigned charge;
    int unsigned recover_lvl;
    logic        low_v;
    logic        shut;
    logic        ok;
    request_e    req;
    req = t.req;
    shut = t.shut;
    if (t.mv > MvValidMin) pm_last_mv = t.mv;
    if (pm_last_mv < 3170) charge = 0;
    else if (pm_last_mv > 3868) charge = 1000;
    else charge = (14292 * int'(pm_last_mv) - 45293000) / 10000;
    low_v = pm_last_mv < 3000;
    recover_lvl = int'(cfg_ext_thr) + int'(cfg_hyst);

    // Power down is consumed here; rails stay as they are
    if (req == REQ_DOWN) begin
      pm_state = PS_STANDBY;
      req = REQ_NONE;
    end

    case (pm_state)
      PS_STANDBY: begin
        if (req == REQ_UP || req == REQ_UP_EXT_DOWN) begin
          if (!low_v || t.vbus) begin
            pm_en3v3 = 1'b1;
            pm_en5v = (req == REQ_UP) && (t.vbus || charge >= cfg_ext_thr);
            pm_off12 = 1'b0;
            pm_vref = 1'b1;
            pm_state = pm_en5v ? PS_POWERED : PS_EXT_DOWN;
          end
          // a power-up tick never honours the shutdown pulse
          shut = 1'b0;
        end
        if (shut) begin
          pm_en5v = 1'b0;
          pm_off12 = 1'b1;
          pm_vref = 1'b0;
          pm_en3v3 = 1'b0;
        end
      end
      PS_POWERED: begin
        if (req == REQ_UP_EXT_DOWN || (!t.vbus && charge < cfg_ext_thr)) begin
          pm_en5v = 1'b0;
          pm_state = PS_EXT_DOWN;
        end
      end
      PS_EXT_DOWN: begin
        ok = t.vbus || charge >= recover_lvl;
        if (cfg_auto && ok) begin
          pm_en5v = 1'b1;
          pm_state = PS_POWERED;
        end else if (req == REQ_UP) begin
          if (ok) begin
            pm_en5v = 1'b1;
            pm_state = PS_POWERED;
          end
        end else if (!t.vbus && charge < cfg_crit_thr) begin
          pm_en5v = 1'b0;
          pm_off12 = 1'b1;
          pm_vref = 1'b0;
          pm_state = PS_STANDBY;
        end
      end
      default: ;
    endcase

    r.pwr_mode = pm_state;
    r.rail_3v3_on = pm_en3v3;
    r.rail_5v_10v_on = pm_en5v;
    r.rail_12v_off = pm_off12;
    r.vref_on = pm_vref;
    r.charge_tenths = charge[ChargeW-1:0];
    if (t.charging) r.charge_status = CS_FAST;
    else if (t.vbus && charge >= 950) r.charge_status = CS_COMPLETE;
    else r.charge_status = CS_NOT_CHARGING;
    r.ext_source = t.vbus;
    r.vsys_low = low_v;
    return r;
  endfunction

  // Random tick: mostly a slow voltage walk around the charge curve
  function automatic tick_t draw_tick();
    tick_t t;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      t.mv = MvW'($urandom_range(0, 100));
    end else if (r < 16) begin
      t.mv = MvW'($urandom_range(0, 8191));
    end else begin
      if (r < 22) walk_mv = int'($urandom_range(2900, 3950));
      walk_mv = walk_mv + int'($urandom_range(0, 80)) - 40;
      if (walk_mv < 2950) walk_mv = 2950;
      if (walk_mv > 3950) walk_mv = 3950;
      t.mv = walk_mv[MvW-1:0];
    end
    if ($urandom_range(0, 19) == 0) vbus_level = !vbus_level;
    t.vbus = vbus_level;
    t.charging = $urandom_range(0, 3) == 0;
    t.shut = $urandom_range(0, 14) == 0;
    r = $urandom_range(0, 99);
    if (r < 60) t.req = REQ_NONE;
    else if (r < 75) t.req = REQ_UP;
    else if (r < 88) t.req = REQ_UP_EXT_DOWN;
    else t.req = REQ_DOWN;
    return t;
  endfunction

  // Offer one tick and hold it until the transfer; valid stays high afterwards
  task automatic offer_tick(input tick_t t, input bit typed, input result_t want);
    result_t pred;
    @(negedge clk);
    in_valid <= 1'b1;
    request <= t.req;
    battery_mv <= t.mv;
    vbus_present <= t.vbus;
    charging <= t.charging;
    shutdown_notified <= t.shut;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = rail_controller_step(t);
    pending_status_q.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // Drop valid for a number of cycles
  task automatic idle_input(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    idle_input(1);
    while (pending_status_q.size() != 0) @(posedge clk);
  endtask

  // Register write: setup then access phase
  task automatic write_reg(input cfg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_AUTO_RECOVER: cfg_auto = val[0];
      REG_EXT_DOWN_THR: cfg_ext_thr = val[ThrW-1:0];
      REG_CRIT_THR:     cfg_crit_thr = val[ThrW-1:0];
      REG_RECOVER_HYST: cfg_hyst = val[ThrW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: check each transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pwr_mode < 2'd3) state_hits[pwr_mode]++;
      if (pending_status_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, state %0d charge %0d",
                 $time, pwr_mode, charge_tenths);
      end else begin
        want = pending_status_q.pop_front();
        cmp_field("pwr_mode", want.pwr_mode, pwr_mode);
        cmp_field("rail_3v3_on", want.rail_3v3_on, rail_3v3_on);
        cmp_field("rail_5v_10v_on", want.rail_5v_10v_on, rail_5v_10v_on);
        cmp_field("rail_12v_off", want.rail_12v_off, rail_12v_off);
        cmp_field("vref_on", want.vref_on, vref_on);
        cmp_field("charge_tenths", want.charge_tenths, charge_tenths);
        cmp_field("charge_status", want.charge_status, charge_status);
        cmp_field("ext_source", want.ext_source, ext_source);
        cmp_field("vsys_low", want.vsys_low, vsys_low);
      end
    end
  end

  // Result ready: random stall patterns, plus long hold-offs on request
  initial begin : result_ready
    int unsigned hold_left;
    int unsigned seg_left;
    int unsigned mode;
    int unsigned pat;
    hold_left = 0;
    seg_left = 0;
    mode = 0;
    pat = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(40, 250);
        end
        seg_left--;
        pat++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 9) < 7;
          2: out_ready <= (pat % 4) != 3;
          default: out_ready <= $urandom_range(0, 9) < 3;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == Limit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, pending_status_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned burst;
    int unsigned gap;
    int unsigned sent;
    logic            p_auto;
    logic [ThrW-1:0] p_ext;
    logic [ThrW-1:0] p_crit;
    logic [ThrW-1:0] p_hyst;

    // req, mv, vbus, charging, shutdown; typed rows follow straight from reset
    dir_rows = '{
      '{'{REQ_NONE,        13'd0,    1'b0, 1'b0, 1'b0}, 1'b1, IdleFlat},
      // power-up with too little power also drops the shutdown pulse
      '{'{REQ_UP,          13'd100,  1'b0, 1'b0, 1'b1}, 1'b1, IdleFlat},
      '{'{REQ_NONE,        13'd8191, 1'b0, 1'b1, 1'b0}, 1'b1, IdleFull},
      '{'{REQ_UP,          13'd101,  1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_UP,          13'd3868, 1'b1, 1'b0, 1'b0}, 1'b0, Untyped},
      // repeated power-up while powered is ignored
      '{'{REQ_UP,          13'd3869, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_UP_EXT_DOWN, 13'd3170, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_UP_EXT_DOWN, 13'd3169, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_NONE,        13'd0,    1'b0, 1'b0, 1'b1}, 1'b0, Untyped},
      '{'{REQ_UP_EXT_DOWN, 13'd3500, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_NONE,        13'd3500, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      // power down keeps the rails until a shutdown pulse
      '{'{REQ_DOWN,        13'd3500, 1'b0, 1'b1, 1'b0}, 1'b0, Untyped},
      '{'{REQ_NONE,        13'd3500, 1'b1, 1'b0, 1'b1}, 1'b0, Untyped},
      '{'{REQ_UP,          13'd3600, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      // shutdown pulse while powered is ignored
      '{'{REQ_NONE,        13'd3600, 1'b0, 1'b0, 1'b1}, 1'b0, Untyped},
      '{'{REQ_NONE,        13'd3250, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_NONE,        13'd3250, 1'b1, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_NONE,        13'd3200, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_NONE,        13'd3200, 1'b0, 1'b0, 1'b0}, 1'b0, Untyped},
      '{'{REQ_UP,          13'd2999, 1'b1, 1'b1, 1'b0}, 1'b0, Untyped},
      '{'{REQ_DOWN,        13'd4096, 1'b1, 1'b0, 1'b1}, 1'b0, Untyped},
      '{'{REQ_UP,          13'd1,    1'b0, 1'b0, 1'b0}, 1'b0, Untyped}
    };

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) offer_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      // register settings for this phase, reset values and extremes first
      case (p)
        0: begin p_auto = 1'b0; p_ext = 10'd150;  p_crit = 10'd50;   p_hyst = 10'd100;  end
        1: begin p_auto = 1'b1; p_ext = 10'd0;    p_crit = 10'd0;    p_hyst = 10'd0;    end
        2: begin p_auto = 1'b0; p_ext = 10'd1023; p_crit = 10'd1023; p_hyst = 10'd1023; end
        3: begin p_auto = 1'b1; p_ext = 10'd1000; p_crit = 10'd1000; p_hyst = 10'd1000; end
        4: begin p_auto = 1'b1; p_ext = 10'd400;  p_crit = 10'd200;  p_hyst = 10'd300;  end
        7: begin p_auto = 1'b1; p_ext = 10'd150;  p_crit = 10'd50;   p_hyst = 10'd100;  end
        default: begin
          p_auto = 1'($urandom_range(0, 1));
          p_ext = ThrW'($urandom_range(0, 1023));
          p_crit = ThrW'($urandom_range(0, 1023));
          p_hyst = ThrW'($urandom_range(0, 1023));
        end
      endcase
      write_reg(REG_AUTO_RECOVER, ApbDataW'(p_auto));
      write_reg(REG_EXT_DOWN_THR, ApbDataW'(p_ext));
      write_reg(REG_CRIT_THR, ApbDataW'(p_crit));
      write_reg(REG_RECOVER_HYST, ApbDataW'(p_hyst));
      settings_used++;

      // back up the result side so the input stalls
      if (p == 2 || p == 5) hold_req = 1'b1;

      sent = 0;
      while (sent < PerPhase) begin
        burst = $urandom_range(1, 30);
        for (int b = 0; b < burst && sent < PerPhase; b++) begin
          offer_tick(draw_tick(), 1'b0, Untyped);
          sent++;
        end
        // phase 1 runs without input gaps
        if (p != 1) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
          if (gap > 0) idle_input(gap);
        end
      end
      drain_results();
    end

    repeat (TailCycles) @(posedge clk);

    $display("Checked %0d of %0d tick transfers over %0d register settings",
             results_seen, ticks_sent, settings_used);
    $display("Results by state: standby %0d, powered %0d, ext rails down %0d",
             state_hits[0], state_hits[1], state_hits[2]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bpsc_pkg.sv
rtl/core/bpsc_charge_est.sv
rtl/core/bpsc_out_fifo.sv
rtl/core/battery_power_state_controller_unit.sv
bench/testbench.sv
